// ===== sv/orbit_camera_controller_assert.svh =====
// Assertion helpers for the orbit camera controller.
// They expect clk and arst_n in scope.
`ifndef ORBIT_CAMERA_CONTROLLER_ASSERT_SVH
`define ORBIT_CAMERA_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define OCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orbit camera assertion failed");

// Next-cycle implication
`define OCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orbit camera assertion failed");

`endif

// ===== sv/occ_pkg.sv =====
// ----------------------------------------------------------------------------
// occ_pkg: shared types and constants
// Command codes, controller/datapath interface structs, CORDIC arctan table.
// ----------------------------------------------------------------------------
`default_nettype none

package occ_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int CNT_W    = 5;
	localparam int IN_W     = 184;
	localparam int OUT_W    = 304;

	localparam logic [25:0] RADIUS_MIN = 26'd6554;
	localparam logic [25:0] RADIUS_MAX = 26'd65536000;
	localparam logic [25:0] RADIUS_RST = 26'd28180480;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

	typedef enum logic [1:0] {
		CMD_ROTATE = 2'd0,
		CMD_ZOOM   = 2'd1,
		CMD_PAN    = 2'd2,
		CMD_SET    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		MUL_ZOOM, MUL_RC, MUL_PX, MUL_PY, MUL_PZ, MUL_UX, MUL_UY
	} mul_op_t;

	typedef enum logic [2:0] {
		WB_NONE, WB_ZOOM, WB_RC, WB_PX, WB_PY, WB_PZ, WB_UX, WB_UY
	} wb_op_t;

	typedef enum logic [4:0] {
		ST_BOOT, ST_IDLE, ST_APPLY, ST_ZWB,
		ST_CH_LD, ST_CH_RUN, ST_CH_ST,
		ST_CV_LD, ST_CV_RUN, ST_CV_ST,
		ST_M_RC, ST_W_RC, ST_M_PX, ST_W_PX, ST_M_PY, ST_W_PY,
		ST_M_PZ, ST_W_PZ, ST_M_UX, ST_W_UX, ST_M_UY, ST_W_UY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             apply;
		logic             cor_load;
		logic             cor_sel;   // 0 horizontal, 1 vertical
		logic             cor_step;
		logic             cor_store;
		logic [CNT_W-1:0] cor_idx;
		mul_op_t          mul_op;
		wb_op_t           wb_op;
		logic             out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic orbit;
	} dp_stat_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_lut(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'd536870912;
			5'd1:    r = 32'd316933406;
			5'd2:    r = 32'd167458907;
			5'd3:    r = 32'd85004756;
			5'd4:    r = 32'd42667331;
			5'd5:    r = 32'd21354465;
			5'd6:    r = 32'd10679838;
			5'd7:    r = 32'd5340245;
			5'd8:    r = 32'd2670163;
			5'd9:    r = 32'd1335087;
			5'd10:   r = 32'd667544;
			5'd11:   r = 32'd333772;
			5'd12:   r = 32'd166886;
			5'd13:   r = 32'd83443;
			5'd14:   r = 32'd41722;
			5'd15:   r = 32'd20861;
			5'd16:   r = 32'd10430;
			5'd17:   r = 32'd5215;
			5'd18:   r = 32'd2608;
			5'd19:   r = 32'd1304;
			5'd20:   r = 32'd652;
			5'd21:   r = 32'd326;
			5'd22:   r = 32'd163;
			5'd23:   r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// saturate to a signed 32-bit coordinate
	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -38'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/orbit_camera_controller.sv =====
// ----------------------------------------------------------------------------
// orbit_camera_controller: orbit camera command processor
// Applies rotate, zoom, pan and set commands and returns the full camera state.
// ----------------------------------------------------------------------------
// One result word per command word. In orbit mode the sin/cos of both
// angles run one after the other through a single iterative CORDIC, then
// six products go through one shared registered multiplier; a zoom first
// writes back the new radius. Free-mode commands skip the CORDIC and the
// products. After reset the block computes the default orbit once with
// s_tready low. A finished word waits in the output register while the next
// command is taken. orbit_enable writes are taken on any cycle with cfg_we.
`default_nettype none

module orbit_camera_controller
	import occ_pkg::*;
#(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// angle_horiz, angle_vert, zoom_factor, vec_x, vec_y, vec_z, new_radius
	input  wire logic [IN_W-1:0]   s_tdata,
	// cmd
	input  wire logic [1:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// pos_x, pos_y, pos_z, look_x, look_y, look_z, up_x, up_y, up_z,
	// cur_horiz, cur_vert, cur_radius
	output logic [OUT_W-1:0]       m_tdata,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata
);

	ctrl_cmd_t ctl;
	dp_stat_t  sts;

	occ_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	occ_dp #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.res       (m_tdata)
	);

	// checks
	`include "orbit_camera_controller_assert.svh"

	`OCC_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready)
	`OCC_ASSERT_IMP(a_up_z_range, m_tvalid, !m_tdata[245] && m_tdata[245:228] <= 18'd65536)
	`OCC_ASSERT_IMP(a_radius_max, m_tvalid, m_tdata[302:277] <= RADIUS_MAX)

endmodule

`default_nettype wire

// ===== sv/occ_dp.sv =====
// ----------------------------------------------------------------------------
// occ_dp: camera datapath
// Camera state, command apply logic, iterative CORDIC, shared multiplier and
// the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_dp
	import occ_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic [1:0]       s_tuser,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire ctrl_cmd_t        ctl,
	output dp_stat_t              sts,
	output logic [OUT_W-1:0]      res
);

	localparam int AB = ANGLE_BITS;
	localparam longint VL_L = ((longint'(89) << AB) + 180) / 360;
	localparam logic signed [AB+1:0] VLIM = (AB+2)'(VL_L);
	localparam logic [AB-1:0] H_RST = AB'(((longint'(4) << AB) + 2) / 5);
	localparam logic [AB-1:0] V_RST = AB'(longint'(1) << (AB - 3));

	// architectural state
	logic               orbit_q;
	logic signed [31:0] centre_q [3];
	logic signed [31:0] pos_q    [3];
	logic signed [31:0] tgt_q    [3];
	logic signed [17:0] up_q     [3];
	logic [AB-1:0]      horiz_q;
	logic signed [AB-1:0] vert_q;
	logic [25:0]        radius_q;

	// captured command word
	cmd_t               cmd_q;
	logic signed [AB-1:0] dh_q, dv_q;
	logic [23:0]        zf_q;
	logic signed [31:0] vec_q [3];
	logic [25:0]        nrad_q;

	// CORDIC and multiplier state
	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q;
	logic signed [17:0] sh_q, ch_q, sv_q, cv_q;
	logic signed [26:0] rc_q;
	logic signed [51:0] mul_q;

	// input angle conversion to AB bits per turn
	logic signed [AB+15:0] dh_w, dv_w;
	assign dh_w = $signed({s_tdata[15:0], {AB{1'b0}}}) >>> 16;
	assign dv_w = $signed({s_tdata[31:16], {AB{1'b0}}}) >>> 16;

	function automatic logic signed [AB-1:0] vclamp(input logic signed [AB+1:0] v);
		logic signed [AB+1:0] r;
		if (v > VLIM) begin
			r = VLIM;
		end else if (v < -VLIM) begin
			r = -VLIM;
		end else begin
			r = v;
		end
		return r[AB-1:0];
	endfunction

	assign sts.cmd   = cmd_q;
	assign sts.orbit = orbit_q;

	// capture of the input word
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd_t'(s_tuser);
			dh_q     <= dh_w[AB-1:0];
			dv_q     <= dv_w[AB-1:0];
			zf_q     <= s_tdata[55:32];
			vec_q[0] <= s_tdata[87:56];
			vec_q[1] <= s_tdata[119:88];
			vec_q[2] <= s_tdata[151:120];
			nrad_q   <= s_tdata[177:152];
		end
	end

	// shared multiplier, registered
	logic signed [26:0] ma;
	logic signed [24:0] mb;
	always_comb begin
		ma = $signed({1'b0, radius_q});
		mb = 25'(cv_q);
		case (ctl.mul_op)
			MUL_ZOOM: begin ma = $signed({1'b0, radius_q}); mb = $signed({1'b0, zf_q}); end
			MUL_RC:   begin ma = $signed({1'b0, radius_q}); mb = 25'(cv_q); end
			MUL_PX:   begin ma = rc_q; mb = 25'(ch_q); end
			MUL_PY:   begin ma = rc_q; mb = 25'(sh_q); end
			MUL_PZ:   begin ma = $signed({1'b0, radius_q}); mb = 25'(sv_q); end
			MUL_UX:   begin ma = 27'(sv_q); mb = 25'(ch_q); end
			MUL_UY:   begin ma = 27'(sv_q); mb = 25'(sh_q); end
			default:  begin ma = 27'(sv_q); mb = 25'(sh_q); end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= 52'(ma * mb);
	end

	// product rounded half up to Q16
	logic signed [51:0] rnd_w;
	logic signed [35:0] rnd16;
	assign rnd_w = (mul_q + 52'sd32768) >>> 16;
	assign rnd16 = rnd_w[35:0];

	// CORDIC step and result rounding
	logic [AB-1:0]      ang_sel;
	logic [31:0]        t_w;
	logic               flip_w;
	logic signed [33:0] xs, ys, at;
	logic signed [33:0] xr_w, yr_w;
	logic signed [17:0] cs_w, sn_w;
	assign ang_sel = ctl.cor_sel ? vert_q : horiz_q;
	assign t_w     = {ang_sel, {(32-AB){1'b0}}};
	assign flip_w  = t_w[31] ^ t_w[30];
	assign xs      = x_q >>> ctl.cor_idx;
	assign ys      = y_q >>> ctl.cor_idx;
	assign at      = $signed({2'b00, atan_lut(ctl.cor_idx)});
	assign xr_w    = (x_q + 34'sd8192) >>> 14;
	assign yr_w    = (y_q + 34'sd8192) >>> 14;

	function automatic logic signed [17:0] clip1(input logic signed [33:0] v,
		input logic neg);
		logic signed [17:0] r;
		if (v > 34'sd65536) begin
			r = 18'sd65536;
		end else if (v < -34'sd65536) begin
			r = -18'sd65536;
		end else begin
			r = v[17:0];
		end
		return neg ? -r : r;
	endfunction

	assign cs_w = clip1(xr_w, flip_q);
	assign sn_w = clip1(yr_w, flip_q);

	always_ff @(posedge clk) begin
		if (ctl.cor_load) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= 34'($signed({t_w[31] ^ flip_w, t_w[30:0]}));
			flip_q <= flip_w;
		end else if (ctl.cor_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
		if (ctl.cor_store) begin
			if (ctl.cor_sel) begin
				cv_q <= cs_w;
				sv_q <= sn_w;
			end else begin
				ch_q <= cs_w;
				sh_q <= sn_w;
			end
		end
	end

	// zoom radius, rounded and clamped
	logic signed [51:0] zr_w;
	logic [25:0]        zoom_rad;
	assign zr_w = (mul_q + 52'sd32768) >>> 16;
	always_comb begin
		if (zr_w < $signed({26'd0, RADIUS_MIN})) begin
			zoom_rad = RADIUS_MIN;
		end else if (zr_w > $signed({26'd0, RADIUS_MAX})) begin
			zoom_rad = RADIUS_MAX;
		end else begin
			zoom_rad = zr_w[25:0];
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbit_q <= 1'b1;
		end else if (cfg_we) begin
			orbit_q <= cfg_wdata;
		end
	end

	// camera parameters: apply and zoom write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_q  <= H_RST;
			vert_q   <= V_RST;
			radius_q <= RADIUS_RST;
			for (int k = 0; k < 3; k++) begin
				centre_q[k] <= '0;
			end
		end else if (ctl.apply) begin
			case (cmd_q)
				CMD_ROTATE: begin
					if (orbit_q) begin
						horiz_q <= horiz_q + dh_q;
						vert_q  <= vclamp((AB+2)'(vert_q) + (AB+2)'(dv_q));
					end
				end
				CMD_PAN: begin
					if (orbit_q) begin
						for (int k = 0; k < 3; k++) begin
							centre_q[k] <= sat32(38'(centre_q[k]) + 38'(vec_q[k]));
						end
					end
				end
				CMD_SET: begin
					horiz_q  <= dh_q;
					vert_q   <= vclamp((AB+2)'(dv_q));
					radius_q <= (nrad_q > RADIUS_MAX) ? RADIUS_MAX : nrad_q;
					for (int k = 0; k < 3; k++) begin
						centre_q[k] <= vec_q[k];
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.wb_op == WB_ZOOM) begin
			radius_q <= zoom_rad;
		end
	end

	// target: reset to zero, free-mode pan, or copy of the centre
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				tgt_q[k] <= '0;
			end
		end else if (ctl.apply && cmd_q == CMD_PAN && !orbit_q) begin
			for (int k = 0; k < 3; k++) begin
				tgt_q[k] <= sat32(38'(tgt_q[k]) + 38'(vec_q[k]));
			end
		end else if (ctl.wb_op == WB_RC) begin
			for (int k = 0; k < 3; k++) begin
				tgt_q[k] <= centre_q[k];
			end
		end
	end

	// position, up vector and r*cos(v) write-back
	always_ff @(posedge clk) begin
		if (ctl.apply && cmd_q == CMD_PAN && !orbit_q) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= sat32(38'(pos_q[k]) + 38'(vec_q[k]));
			end
		end
		case (ctl.wb_op)
			WB_RC: begin
				rc_q     <= rnd16[26:0];
				up_q[2]  <= cv_q;
			end
			WB_PX:   pos_q[0] <= sat32(38'(centre_q[0]) + 38'(rnd16));
			WB_PY:   pos_q[1] <= sat32(38'(centre_q[1]) + 38'(rnd16));
			WB_PZ:   pos_q[2] <= sat32(38'(centre_q[2]) + 38'(rnd16));
			WB_UX:   up_q[0]  <= -rnd16[17:0];
			WB_UY:   up_q[1]  <= -rnd16[17:0];
			default: begin
			end
		endcase
	end

	// output word, angles rescaled to 65536 per turn
	logic [AB+15:0] hw;
	logic [AB+15:0] vw;
	assign hw = {horiz_q, 16'd0};
	assign vw = {vert_q, 16'd0};

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res <= {1'b0, radius_q, vw[AB+14:AB], hw[AB+15:AB],
				up_q[2], up_q[1], up_q[0],
				tgt_q[2], tgt_q[1], tgt_q[0],
				pos_q[2], pos_q[1], pos_q[0]};
		end
	end

endmodule

`default_nettype wire

// ===== sv/occ_ctrl.sv =====
// ----------------------------------------------------------------------------
// occ_ctrl: command sequencer
// Steps each command through apply and, in orbit mode, two CORDIC runs and
// six multiplies, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module occ_ctrl
	import occ_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire dp_stat_t sts,
	output ctrl_cmd_t     ctl
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             boot_q;
	logic             vld_q;

	// state, step counter, boot flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BOOT;
			cnt_q   <= '0;
			boot_q  <= 1'b1;
			vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CH_RUN || state_q == ST_CV_RUN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == ST_W_UY) begin
				boot_q <= 1'b0;
			end
			if (ctl.out_load) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = vld_q;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		ctl         = '0;
		ctl.mul_op  = MUL_ZOOM;
		ctl.wb_op   = WB_NONE;
		ctl.cor_idx = cnt_q;
		case (state_q)
			ST_BOOT: state_d = ST_CH_LD;
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.capture = 1'b1;
					state_d     = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctl.apply = 1'b1;
				if (!sts.orbit) begin
					state_d = ST_DONE;
				end else if (sts.cmd == CMD_ZOOM) begin
					state_d = ST_ZWB;
				end else begin
					state_d = ST_CH_LD;
				end
			end
			ST_ZWB: begin
				ctl.wb_op = WB_ZOOM;
				state_d   = ST_CH_LD;
			end
			ST_CH_LD: begin
				ctl.cor_load = 1'b1;
				state_d      = ST_CH_RUN;
			end
			ST_CH_RUN: begin
				ctl.cor_step = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_CH_ST;
				end
			end
			ST_CH_ST: begin
				ctl.cor_store = 1'b1;
				state_d       = ST_CV_LD;
			end
			ST_CV_LD: begin
				ctl.cor_load = 1'b1;
				ctl.cor_sel  = 1'b1;
				state_d      = ST_CV_RUN;
			end
			ST_CV_RUN: begin
				ctl.cor_step = 1'b1;
				ctl.cor_sel  = 1'b1;
				if (cnt_q == LAST) begin
					state_d = ST_CV_ST;
				end
			end
			ST_CV_ST: begin
				ctl.cor_store = 1'b1;
				ctl.cor_sel   = 1'b1;
				state_d       = ST_M_RC;
			end
			ST_M_RC: begin ctl.mul_op = MUL_RC; state_d = ST_W_RC; end
			ST_W_RC: begin ctl.wb_op  = WB_RC;  state_d = ST_M_PX; end
			ST_M_PX: begin ctl.mul_op = MUL_PX; state_d = ST_W_PX; end
			ST_W_PX: begin ctl.wb_op  = WB_PX;  state_d = ST_M_PY; end
			ST_M_PY: begin ctl.mul_op = MUL_PY; state_d = ST_W_PY; end
			ST_W_PY: begin ctl.wb_op  = WB_PY;  state_d = ST_M_PZ; end
			ST_M_PZ: begin ctl.mul_op = MUL_PZ; state_d = ST_W_PZ; end
			ST_W_PZ: begin ctl.wb_op  = WB_PZ;  state_d = ST_M_UX; end
			ST_M_UX: begin ctl.mul_op = MUL_UX; state_d = ST_W_UX; end
			ST_W_UX: begin ctl.wb_op  = WB_UX;  state_d = ST_M_UY; end
			ST_M_UY: begin ctl.mul_op = MUL_UY; state_d = ST_W_UY; end
			ST_W_UY: begin
				ctl.wb_op = WB_UY;
				state_d   = boot_q ? ST_IDLE : ST_DONE;
			end
			ST_DONE: begin
				if (!vld_q || m_tready) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire
